// ===== hdl/scctu_pkg.sv =====
package scctu_pkg;

    localparam int TS_W     = 32;
    localparam int TICK_W   = 16;
    localparam int IN_W     = 32;
    localparam int RAD_W    = 31;
    localparam int DT_W     = TS_W + TICK_W;
    localparam int MUL_LAT  = 5;
    localparam int CHUNK    = 32;

    localparam logic [TS_W-1:0] TS_RESET = 32'h0001_0000;

    typedef struct packed {
        logic signed [IN_W-1:0]  own_pos_x;
        logic signed [IN_W-1:0]  own_pos_y;
        logic signed [IN_W-1:0]  own_vel_x;
        logic signed [IN_W-1:0]  own_vel_y;
        logic        [RAD_W-1:0] own_radius;
        logic signed [IN_W-1:0]  other_pos_x;
        logic signed [IN_W-1:0]  other_pos_y;
        logic signed [IN_W-1:0]  other_vel_x;
        logic signed [IN_W-1:0]  other_vel_y;
        logic        [RAD_W-1:0] other_radius;
        logic        [TICK_W-1:0] elapsed_ticks;
    } t_item;

    typedef struct packed {
        logic collide;
        logic paths_cross;
    } t_result;

endpackage

// ===== hdl/scctu_mul.sv =====
module scctu_mul
    import scctu_pkg::*;
#(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                  i_clk,
    input  logic signed [WA-1:0]  i_a,
    input  logic signed [WB-1:0]  i_b,
    output logic signed [WA+WB-1:0] o_p
);

    // sign/magnitude, 32x32 partial products, row sums, total, sign
    localparam int NA   = (WA + CHUNK - 1) / CHUNK;
    localparam int NB   = (WB + CHUNK - 1) / CHUNK;
    localparam int PA   = NA * CHUNK;
    localparam int PB   = NB * CHUNK;
    localparam int ROWW = CHUNK + PB;
    localparam int TW   = PA + PB;
    localparam int OW   = WA + WB;

    logic [WA-1:0]        r_ma;
    logic [WB-1:0]        r_mb;
    logic                 r_sg1, r_sg2, r_sg3, r_sg4;
    logic [2*CHUNK-1:0]   r_pp [NA][NB];
    logic [ROWW-1:0]      r_row [NA];
    logic [ROWW-1:0]      n_row [NA];
    logic [TW-1:0]        r_tot;
    logic [TW-1:0]        n_tot;
    logic signed [OW-1:0] r_p;
    logic [PA-1:0]        w_pa;
    logic [PB-1:0]        w_pb;

    assign w_pa = PA'(r_ma);
    assign w_pb = PB'(r_mb);

    always_ff @(posedge i_clk) begin
        r_ma  <= i_a[WA-1] ? (~i_a + 1'b1) : i_a;
        r_mb  <= i_b[WB-1] ? (~i_b + 1'b1) : i_b;
        r_sg1 <= i_a[WA-1] ^ i_b[WB-1];
        r_sg2 <= r_sg1;
        r_sg3 <= r_sg2;
        r_sg4 <= r_sg3;
    end

    for (genvar i = 0; i < NA; i++) begin : g_ra
        for (genvar j = 0; j < NB; j++) begin : g_rb
            always_ff @(posedge i_clk) begin
                r_pp[i][j] <= (2*CHUNK)'(w_pa[i*CHUNK +: CHUNK]) *
                              (2*CHUNK)'(w_pb[j*CHUNK +: CHUNK]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (ROWW'(r_pp[i][j]) << (j*CHUNK));
            end
        end
    end

    always_comb begin
        n_tot = '0;
        for (int i = 0; i < NA; i++) begin
            n_tot = n_tot + (TW'(r_row[i]) << (i*CHUNK));
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_tot <= n_tot;
        r_p   <= r_sg4 ? -$signed(r_tot[OW-1:0]) : $signed(r_tot[OW-1:0]);
    end

    assign o_p = r_p;

endmodule

// ===== hdl/swept_circle_collision_test_unit.sv =====
// An accepted transfer passes the unit's own stages and three 5-stage multipliers before its o_strobe.
// Throughput: one transfer per cycle; busy is never asserted and results cannot be stalled.
// The three chained multiplier pipelines (sweep, geometry products, final squares) set latency.
// Reset: synchronous, active low; clears the valid pipeline and restores time_scale to 1.0.
// Data registers are not reset.
module swept_circle_collision_test_unit
    import scctu_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    input  logic             i_cfg_we,
    input  logic [TS_W-1:0]  i_cfg_wdata,
    output t_result          o_result,
    output logic             o_strobe
);

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 1;
    localparam int RW   = RAD_W + 2;
    localparam int RRW  = 2 * RW;
    localparam int L2W  = 2 * SW;
    localparam int CMPW = (L2W > RRW + SW) ? L2W : RRW + SW;
    localparam int DTB  = DT_W + 1;
    localparam int M0W  = IN_W + DTB;
    localparam int EW   = M0W + 1;
    localparam int N1   = 46;
    localparam int ML   = MUL_LAT;
    localparam int LAT  = 6 + 3 * MUL_LAT;

    localparam logic signed [EW-1:0] MAXE = (EW'(1) << (C-1)) - EW'(1);
    localparam logic signed [EW-1:0] MINE = ~MAXE;

    function automatic logic signed [C-1:0] sat_crd(input logic signed [EW-1:0] v);
        logic signed [C-1:0] r;
        if (v > MAXE) begin
            r = MAXE[C-1:0];
        end else if (v < MINE) begin
            r = MINE[C-1:0];
        end else begin
            r = v[C-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] dif(input logic signed [C-1:0] a,
                                                 input logic signed [C-1:0] b);
        return DW'(a) - DW'(b);
    endfunction

    function automatic logic in_unit(input logic signed [SW-1:0] num,
                                     input logic signed [SW-1:0] den);
        logic r;
        if (den > 0) begin
            r = (num >= 0) && (num <= den);
        end else begin
            r = (num <= 0) && (num >= den);
        end
        return r;
    endfunction

    // control
    logic [TS_W-1:0] r_time_scale;
    logic [LAT-1:0]  r_vld;

    assign busy     = 1'b0;
    assign o_strobe = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_scale <= TS_RESET;
            r_vld        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_time_scale <= i_cfg_wdata;
            end
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // stage 1: capture, dt, radius sum
    t_item           r_s1_item;
    logic [DT_W-1:0] r_s1_dt;
    logic [RW-2:0]   r_s1_rsum;

    always_ff @(posedge i_clk) begin
        r_s1_item <= i_item;
        r_s1_dt   <= DT_W'(i_item.elapsed_ticks) * DT_W'(r_time_scale);
        r_s1_rsum <= (RW-1)'(i_item.own_radius) + (RW-1)'(i_item.other_radius);
    end

    // sweep products
    logic signed [IN_W-1:0] w_vel [4];
    logic signed [IN_W-1:0] w_pos [4];
    logic signed [M0W-1:0]  w_m0 [4];

    assign w_vel[0] = r_s1_item.own_vel_x;
    assign w_vel[1] = r_s1_item.own_vel_y;
    assign w_vel[2] = r_s1_item.other_vel_x;
    assign w_vel[3] = r_s1_item.other_vel_y;
    assign w_pos[0] = r_s1_item.own_pos_x;
    assign w_pos[1] = r_s1_item.own_pos_y;
    assign w_pos[2] = r_s1_item.other_pos_x;
    assign w_pos[3] = r_s1_item.other_pos_y;

    for (genvar i = 0; i < 4; i++) begin : g_m0
        scctu_mul #(.WA(IN_W), .WB(DTB)) u_mul (
            .i_clk (i_clk),
            .i_a   (w_vel[i]),
            .i_b   ($signed({1'b0, r_s1_dt})),
            .o_p   (w_m0[i])
        );
    end

    logic signed [IN_W-1:0] r_d0_pos  [ML][4];
    logic [RW-2:0]          r_d0_rsum [ML];

    always_ff @(posedge i_clk) begin
        r_d0_pos[0]  <= w_pos;
        r_d0_rsum[0] <= r_s1_rsum;
        for (int i = 1; i < ML; i++) begin
            r_d0_pos[i]  <= r_d0_pos[i-1];
            r_d0_rsum[i] <= r_d0_rsum[i-1];
        end
    end

    // stage 2: path ends, saturated
    logic signed [C-1:0] r_pt [4][2];
    logic signed [C-1:0] n_pt [4][2];
    logic [RW-2:0]       r_s2_rsum;

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            for (int c = 0; c < 2; c++) begin
                n_pt[2*s][c]   = sat_crd(EW'(r_d0_pos[ML-1][2*s+c]));
                n_pt[2*s+1][c] = sat_crd(EW'(r_d0_pos[ML-1][2*s+c]) -
                                         EW'(w_m0[2*s+c] >>> FRAC_BITS));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt      <= n_pt;
        r_s2_rsum <= r_d0_rsum[ML-1];
    end

    // stage 3: differences into product operands
    logic signed [DW-1:0] r_l1a [N1];
    logic signed [DW-1:0] r_l1b [N1];
    logic signed [DW-1:0] n_l1a [N1];
    logic signed [DW-1:0] n_l1b [N1];
    logic signed [RW-1:0] r_s3_rs;
    logic                 r_s3_rnz;

    always_comb begin
        logic signed [DW-1:0] dax, day, dbx, dby, ex, ey;
        logic signed [DW-1:0] dx, dy, wx, wy, vx, vy;
        int s1, b;
        dax = dif(r_pt[1][0], r_pt[0][0]);
        day = dif(r_pt[1][1], r_pt[0][1]);
        dbx = dif(r_pt[3][0], r_pt[2][0]);
        dby = dif(r_pt[3][1], r_pt[2][1]);
        ex  = dif(r_pt[0][0], r_pt[2][0]);
        ey  = dif(r_pt[0][1], r_pt[2][1]);
        n_l1a[0] = dax; n_l1b[0] = dby;
        n_l1a[1] = day; n_l1b[1] = dbx;
        n_l1a[2] = dax; n_l1b[2] = ey;
        n_l1a[3] = day; n_l1b[3] = ex;
        n_l1a[4] = dbx; n_l1b[4] = ey;
        n_l1a[5] = dby; n_l1b[5] = ex;
        // point k against the other path
        for (int k = 0; k < 4; k++) begin
            s1 = (k < 2) ? 2 : 0;
            b  = 6 + 10 * k;
            dx = dif(r_pt[s1+1][0], r_pt[s1][0]);
            dy = dif(r_pt[s1+1][1], r_pt[s1][1]);
            wx = dif(r_pt[k][0], r_pt[s1][0]);
            wy = dif(r_pt[k][1], r_pt[s1][1]);
            vx = dif(r_pt[k][0], r_pt[s1+1][0]);
            vy = dif(r_pt[k][1], r_pt[s1+1][1]);
            n_l1a[b]   = dx; n_l1b[b]   = dx;
            n_l1a[b+1] = dy; n_l1b[b+1] = dy;
            n_l1a[b+2] = wx; n_l1b[b+2] = dx;
            n_l1a[b+3] = wy; n_l1b[b+3] = dy;
            n_l1a[b+4] = wx; n_l1b[b+4] = wx;
            n_l1a[b+5] = wy; n_l1b[b+5] = wy;
            n_l1a[b+6] = vx; n_l1b[b+6] = vx;
            n_l1a[b+7] = vy; n_l1b[b+7] = vy;
            n_l1a[b+8] = dx; n_l1b[b+8] = wy;
            n_l1a[b+9] = dy; n_l1b[b+9] = wx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1a    <= n_l1a;
        r_l1b    <= n_l1b;
        r_s3_rs  <= $signed({1'b0, r_s2_rsum});
        r_s3_rnz <= |r_s2_rsum;
    end

    // geometry products
    logic signed [PW-1:0]  w_p1 [N1];
    logic signed [RRW-1:0] w_rr;

    for (genvar i = 0; i < N1; i++) begin : g_m1
        scctu_mul #(.WA(DW), .WB(DW)) u_mul (
            .i_clk (i_clk),
            .i_a   (r_l1a[i]),
            .i_b   (r_l1b[i]),
            .o_p   (w_p1[i])
        );
    end

    scctu_mul #(.WA(RW), .WB(RW)) u_mul_rr (
        .i_clk (i_clk),
        .i_a   (r_s3_rs),
        .i_b   (r_s3_rs),
        .o_p   (w_rr)
    );

    logic r_d1_rnz [ML];

    always_ff @(posedge i_clk) begin
        r_d1_rnz[0] <= r_s3_rnz;
        for (int i = 1; i < ML; i++) begin
            r_d1_rnz[i] <= r_d1_rnz[i-1];
        end
    end

    // stage 4: dot and cross sums
    logic signed [SW-1:0]  r_det, r_n1, r_n2;
    logic signed [SW-1:0]  r_den [4];
    logic signed [SW-1:0]  r_proj [4];
    logic signed [SW-1:0]  r_wd [4];
    logic signed [SW-1:0]  r_vd [4];
    logic signed [SW-1:0]  r_c [4];
    logic signed [RRW-1:0] r_s4_rr;
    logic                  r_s4_rnz;

    always_ff @(posedge i_clk) begin
        r_det    <= SW'(w_p1[0]) - SW'(w_p1[1]);
        r_n1     <= SW'(w_p1[2]) - SW'(w_p1[3]);
        r_n2     <= SW'(w_p1[4]) - SW'(w_p1[5]);
        for (int k = 0; k < 4; k++) begin
            r_den[k]  <= SW'(w_p1[6+10*k])   + SW'(w_p1[7+10*k]);
            r_proj[k] <= SW'(w_p1[8+10*k])   + SW'(w_p1[9+10*k]);
            r_wd[k]   <= SW'(w_p1[10+10*k])  + SW'(w_p1[11+10*k]);
            r_vd[k]   <= SW'(w_p1[12+10*k])  + SW'(w_p1[13+10*k]);
            r_c[k]    <= SW'(w_p1[14+10*k])  - SW'(w_p1[15+10*k]);
        end
        r_s4_rr  <= w_rr;
        r_s4_rnz <= r_d1_rnz[ML-1];
    end

    // stage 5: crossing test, pick squared distance as num/den
    logic signed [SW-1:0]  r_l2a [4];
    logic signed [SW-1:0]  r_l2b [4];
    logic signed [SW-1:0]  r_l2d [4];
    logic signed [SW-1:0]  n_l2a [4];
    logic signed [SW-1:0]  n_l2b [4];
    logic signed [SW-1:0]  n_l2d [4];
    logic signed [RRW-1:0] r_s5_rr;
    logic                  r_s5_cross, r_s5_rnz;
    logic                  w_cross;

    assign w_cross = (r_det != '0) && in_unit(r_n1, r_det) && in_unit(r_n2, -r_det);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_den[k] == '0 || r_proj[k] < 0) begin
                n_l2a[k] = r_wd[k];
                n_l2b[k] = SW'(1);
                n_l2d[k] = SW'(1);
            end else if (r_proj[k] > r_den[k]) begin
                n_l2a[k] = r_vd[k];
                n_l2b[k] = SW'(1);
                n_l2d[k] = SW'(1);
            end else begin
                n_l2a[k] = r_c[k];
                n_l2b[k] = r_c[k];
                n_l2d[k] = r_den[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_l2a      <= n_l2a;
        r_l2b      <= n_l2b;
        r_l2d      <= n_l2d;
        r_s5_rr    <= r_s4_rr;
        r_s5_cross <= w_cross;
        r_s5_rnz   <= r_s4_rnz;
    end

    // final squares
    logic signed [L2W-1:0]    w_q1 [4];
    logic signed [RRW+SW-1:0] w_q2 [4];

    for (genvar k = 0; k < 4; k++) begin : g_m2
        scctu_mul #(.WA(SW), .WB(SW)) u_mul_num (
            .i_clk (i_clk),
            .i_a   (r_l2a[k]),
            .i_b   (r_l2b[k]),
            .o_p   (w_q1[k])
        );
        scctu_mul #(.WA(RRW), .WB(SW)) u_mul_lim (
            .i_clk (i_clk),
            .i_a   (r_s5_rr),
            .i_b   (r_l2d[k]),
            .o_p   (w_q2[k])
        );
    end

    logic r_d2_cross [ML];
    logic r_d2_rnz   [ML];

    always_ff @(posedge i_clk) begin
        r_d2_cross[0] <= r_s5_cross;
        r_d2_rnz[0]   <= r_s5_rnz;
        for (int i = 1; i < ML; i++) begin
            r_d2_cross[i] <= r_d2_cross[i-1];
            r_d2_rnz[i]   <= r_d2_rnz[i-1];
        end
    end

    // stage 6: compare and output
    logic [3:0] w_lt;
    t_result    r_result;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_lt[k] = CMPW'(w_q1[k]) < CMPW'(w_q2[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.paths_cross <= r_d2_cross[ML-1];
        r_result.collide     <= r_d2_cross[ML-1] ? r_d2_rnz[ML-1] : |w_lt;
    end

    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("transfer did not emerge after pipeline latency");

    a_cross_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.paths_cross) |-> (o_result.collide == $past(r_d2_rnz[ML-1])))
        else $error("crossing paths gave wrong collide");

    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_strobe)
        else $error("strobe just after reset");
`endif

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import scctu_pkg::*;

    typedef logic signed [255:0] t_wide;

    localparam int LATENCY   = 21;
    localparam int STALL_MAX = 5000;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    i_cfg_we;
    logic [TS_W-1:0] i_cfg_wdata;
    t_result o_result;
    logic    o_strobe;

    logic [TS_W-1:0] scale_q;
    t_result         hit_q[$];
    int              n_err;
    int              quiet_cycles;
    int              idle_pct;

    swept_circle_collision_test_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_wide clamp32(t_wide a);
        if (a > t_wide'(64'sd2147483647)) return t_wide'(64'sd2147483647);
        if (a < -t_wide'(64'sd2147483648)) return -t_wide'(64'sd2147483648);
        return a;
    endfunction

    function automatic t_wide cross2(t_wide ax, t_wide ay, t_wide bx, t_wide by);
        return ax * by - ay * bx;
    endfunction

    function automatic bit in_unit(t_wide num, t_wide den);
        if (den > 0) return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    // squared point-to-segment distance below rr, kept as an exact fraction
    function automatic bit near_seg(t_wide px, t_wide py, t_wide ax, t_wide ay,
                                    t_wide bx, t_wide by, t_wide rr);
        t_wide dx, dy, wx, wy, den, num, proj, c;
        dx = bx - ax;
        dy = by - ay;
        wx = px - ax;
        wy = py - ay;
        den = dx * dx + dy * dy;
        proj = wx * dx + wy * dy;
        if (den == 0 || proj < 0) begin
            num = wx * wx + wy * wy;
            den = 1;
        end else if (proj > den) begin
            num = (px - bx) * (px - bx) + (py - by) * (py - by);
            den = 1;
        end else begin
            c = cross2(dx, dy, wx, wy);
            num = c * c;
        end
        return num < rr * den;
    endfunction

    function automatic void sweep_path(logic signed [31:0] px, logic signed [31:0] py,
                                       logic signed [31:0] vx, logic signed [31:0] vy,
                                       t_wide dt, output t_wide sx, output t_wide sy,
                                       output t_wide ex, output t_wide ey);
        t_wide wx, wy;
        wx = t_wide'(px);
        wy = t_wide'(py);
        sx = clamp32(wx);
        sy = clamp32(wy);
        ex = clamp32(wx - ((t_wide'(vx) * dt) >>> 16));
        ey = clamp32(wy - ((t_wide'(vy) * dt) >>> 16));
    endfunction

    function automatic t_result predict_hit(t_item it, logic [TS_W-1:0] scale);
        t_wide dt, rsum, rr, a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
        t_wide dax, day, dbx, dby, ex, ey, d;
        t_result r;
        dt = t_wide'({208'b0, 48'(it.elapsed_ticks) * 48'(scale)});
        rsum = t_wide'({225'b0, it.own_radius}) + t_wide'({225'b0, it.other_radius});
        rr = rsum * rsum;
        sweep_path(it.own_pos_x, it.own_pos_y, it.own_vel_x, it.own_vel_y, dt,
                   a1x, a1y, a2x, a2y);
        sweep_path(it.other_pos_x, it.other_pos_y, it.other_vel_x, it.other_vel_y, dt,
                   b1x, b1y, b2x, b2y);
        dax = a2x - a1x;
        day = a2y - a1y;
        dbx = b2x - b1x;
        dby = b2y - b1y;
        ex = a1x - b1x;
        ey = a1y - b1y;
        d = cross2(dax, day, dbx, dby);
        r.paths_cross = d != 0 && in_unit(cross2(dax, day, ex, ey), d)
                        && in_unit(cross2(dbx, dby, ex, ey), -d);
        if (r.paths_cross)
            r.collide = rsum > 0;
        else
            r.collide = near_seg(a1x, a1y, b1x, b1y, b2x, b2y, rr)
                     || near_seg(a2x, a2y, b1x, b1y, b2x, b2y, rr)
                     || near_seg(b1x, b1y, a1x, a1y, a2x, a2y, rr)
                     || near_seg(b2x, b2y, a1x, a1y, a2x, a2y, rr);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        int      quiet_n;
        if (i_rst_n) begin
            quiet_n = quiet_cycles + 1;
            if (start && !busy) begin
                hit_q.push_back(predict_hit(i_item, scale_q));
                quiet_n = 0;
            end
            if (o_strobe) begin
                quiet_n = 0;
                if (hit_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected transfer: %b", o_result);
                end else begin
                    exp_r = hit_q.pop_front();
                    if (o_result.collide !== exp_r.collide
                        || o_result.paths_cross !== exp_r.paths_cross) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("collide exp %b got %b, paths_cross exp %b got %b",
                                     exp_r.collide, o_result.collide,
                                     exp_r.paths_cross, o_result.paths_cross);
                    end
                end
            end
            quiet_cycles <= quiet_n;
            if (quiet_n >= STALL_MAX) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] q16(int n);
        return 32'(n * 65536);
    endfunction

    function automatic t_item mk(int px, int py, int vx, int vy, int r,
                                 int ox, int oy, int ovx, int ovy, int orr, int t);
        t_item it;
        it.own_pos_x = q16(px);
        it.own_pos_y = q16(py);
        it.own_vel_x = q16(vx);
        it.own_vel_y = q16(vy);
        it.own_radius = 31'(r * 65536);
        it.other_pos_x = q16(ox);
        it.other_pos_y = q16(oy);
        it.other_vel_x = q16(ovx);
        it.other_vel_y = q16(ovy);
        it.other_radius = 31'(orr * 65536);
        it.elapsed_ticks = 16'(t);
        return it;
    endfunction

    function automatic logic signed [31:0] near_coord(int span);
        return 32'($urandom_range(2 * span * 65536) - span * 65536);
    endfunction

    function automatic t_item rand_scene();
        t_item it;
        int sel;
        sel = $urandom_range(9);
        if (sel < 2) begin
            it.own_pos_x = $urandom;
            it.own_pos_y = $urandom;
            it.own_vel_x = $urandom;
            it.own_vel_y = $urandom;
            it.own_radius = 31'($urandom);
            it.other_pos_x = $urandom;
            it.other_pos_y = $urandom;
            it.other_vel_x = $urandom;
            it.other_vel_y = $urandom;
            it.other_radius = 31'($urandom);
            it.elapsed_ticks = 16'($urandom);
        end else begin
            it.own_pos_x = near_coord(60);
            it.own_pos_y = near_coord(60);
            it.own_vel_x = near_coord(8);
            it.own_vel_y = near_coord(8);
            it.own_radius = 31'($urandom_range(15 * 65536));
            it.other_pos_x = near_coord(60);
            it.other_pos_y = near_coord(60);
            it.other_vel_x = near_coord(8);
            it.other_vel_y = near_coord(8);
            it.other_radius = 31'($urandom_range(15 * 65536));
            it.elapsed_ticks = 16'($urandom_range(12));
            if (sel == 2) begin
                it.other_vel_x = it.own_vel_x;
                it.other_vel_y = it.own_vel_y;
            end
            if (sel == 3) it.elapsed_ticks = 16'($urandom);
        end
        return it;
    endfunction

    task automatic send_item(t_item it);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_scale(logic [TS_W-1:0] v);
        start = 1'b0;
        while (hit_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(posedge i_clk);
        scale_q = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_directed();
        t_item it;
        idle_pct = 0;
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        send_item(mk(0, 0, 10, 0, 0, 5, -5, 0, 10, 0, 1));
        send_item(mk(0, 0, 10, 0, 1, 5, -5, 0, 10, 1, 1));
        send_item(mk(0, 0, 10, 0, 1, 0, 3, 10, 0, 1, 1));
        send_item(mk(0, 0, 10, 0, 2, 0, 3, 10, 0, 2, 1));
        send_item(mk(0, 0, 10, 0, 1, 20, 0, 10, 0, 1, 1));
        send_item(mk(0, 0, 10, 0, 1, 5, 0, 10, 0, 1, 1));
        send_item(mk(3, 4, 0, 0, 2, 0, 0, 0, 0, 3, 0));
        send_item(mk(3, 4, 0, 0, 2, 0, 0, 0, 0, 3, 5));
        send_item(mk(0, 0, 10, 10, 1, 10, 0, -10, 10, 0, 1));
        send_item(mk(5, 3, 0, 0, 1, 0, 0, -10, 0, 1, 1));
        it = '1;
        send_item(it);
        it = '0;
        send_item(it);
        it = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h7fffffff,
              16'hffff};
        send_item(it);
        it = {32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h0,
              32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 31'h0,
              16'hffff};
        send_item(it);
        it = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        it.own_radius = 31'h7fffffff;
        it.other_radius = 31'h7fffffff;
        it.other_pos_x = 32'h80000000;
        it.own_pos_x = 32'h7fffffff;
        send_item(it);
    endtask

    task automatic test_random(int n, int pct);
        idle_pct = pct;
        repeat (n) begin
            send_item(rand_scene());
            if ($urandom_range(49) == 0) begin
                start = 1'b0;
                repeat ($urandom_range(30)) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        scale_q = TS_RESET;
        n_err = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(300, 0);
        set_scale(32'h0);
        test_directed();
        test_random(100, 60);
        set_scale(32'hffff_ffff);
        test_directed();
        test_random(150, 17);
        set_scale(32'h0000_8000);
        test_random(250, 60);
        set_scale($urandom);
        test_random(150, 17);
        set_scale(TS_RESET);
        test_random(100, 0);

        start = 1'b0;
        while (hit_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (n_err == 0 && hit_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
